[src/kkt_pkg.sv]
// ----------------------------------------------------------------------------
// kkt_pkg
// Shared types and codes for the k-bucket routing table.
// ----------------------------------------------------------------------------
package kkt_pkg;

    localparam int KKT_BUCKET_DEPTH = 16;
    localparam int KKT_PAYLOAD_BITS = 64;
    localparam int KKT_BUCKET_COUNT = 256;

    localparam int ID_BITS    = 256;
    localparam int WORD_BITS  = 64;
    localparam int STAMP_BITS = 64;
    localparam int CHK_BITS   = 16;

    // action codes
    localparam logic [2:0] ACT_INSERT = 3'd0;
    localparam logic [2:0] ACT_REMOVE = 3'd1;
    localparam logic [2:0] ACT_FIND   = 3'd2;
    localparam logic [2:0] ACT_ALIVE  = 3'd3;
    localparam logic [2:0] ACT_DEAD   = 3'd4;

    // result status codes
    localparam logic [3:0] ST_SELF        = 4'd0;
    localparam logic [3:0] ST_UPDATED     = 4'd1;
    localparam logic [3:0] ST_ADDED       = 4'd2;
    localparam logic [3:0] ST_REPLACEMENT = 4'd3;
    localparam logic [3:0] ST_REMOVED     = 4'd4;
    localparam logic [3:0] ST_NOT_FOUND   = 4'd5;
    localparam logic [3:0] ST_FOUND_LIVE  = 4'd6;
    localparam logic [3:0] ST_FOUND_CACHE = 4'd7;
    localparam logic [3:0] ST_ALIVE       = 4'd8;
    localparam logic [3:0] ST_DEAD_PROMO  = 4'd9;
    localparam logic [3:0] ST_DEAD_NONE   = 4'd10;

    localparam logic [1:0] CFG_LOCAL_W0 = 2'd0;
    localparam logic [1:0] CFG_LOCAL_W1 = 2'd1;
    localparam logic [1:0] CFG_LOCAL_W2 = 2'd2;
    localparam logic [1:0] CFG_LOCAL_W3 = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BKT,
        S_CNT_RD,
        S_CNT_GET,
        S_SCAN_LIVE,
        S_SCAN_CACHE,
        S_SHIFT,
        S_WRITE,
        S_FINISH
    } state_t;

    typedef enum logic [1:0] {
        AFT_FINISH,
        AFT_WRITE,
        AFT_SCAN
    } after_t;

endpackage

[src/kademlia_kbucket_table_top.sv]
// ----------------------------------------------------------------------------
// kademlia_kbucket_table_top
// Kademlia routing table: 256 k-buckets, each with an LRU live list and a
// replacement cache, held in one slot memory and one count memory.
// ----------------------------------------------------------------------------
//  channel  | direction | payload (tdata, lowest bit first)
//  s_t*     | in        | action[3], id_word0..3[64 each], node_payload[64],
//           |           | node_checks[16], 5 zero bits
//  m_t*     | out       | status[4], bucket_index[8], hit_payload[64],
//           |           | hit_stamp[64], hit_checks[16], 4 zero bits
//  cfg_*    | in        | write: index 0..3 = local_id_word0..3
//
// One item at a time. Bucket search takes one 64-bit word a cycle, then
// the count memory is read. A list scan, and a shift of the entries behind
// a position, move one slot a cycle through the single slot memory read port;
// write and finish are states of their own. The worst case is mark dead with
// promotion, which scans and shifts both lists. Reset clears counts through
// per-bucket valid bits and the stamp clock; slot memory needs no clear. A
// result waits in the output register; the next item is taken meanwhile and
// holds in its last cycle until that register is free.
// ----------------------------------------------------------------------------
module kademlia_kbucket_table_top
    import kkt_pkg::*;
#(
    parameter int BUCKET_DEPTH = KKT_BUCKET_DEPTH,
    parameter int PAYLOAD_BITS = KKT_PAYLOAD_BITS
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // action, id_word0, id_word1, id_word2, id_word3, node_payload,
    // node_checks, zero pad
    input  logic [343:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status, bucket_index, hit_payload, hit_stamp, hit_checks, zero pad
    output logic [159:0] m_tdata,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [63:0]  cfg_data
);

    localparam int IW    = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
    localparam int CW    = $clog2(BUCKET_DEPTH + 1);
    localparam int AW    = 8 + 1 + IW;
    localparam int SLOTS = 1 << AW;

    typedef struct packed {
        logic [ID_BITS-1:0]      id;
        logic [PAYLOAD_BITS-1:0] pay;
        logic [STAMP_BITS-1:0]   stamp;
        logic [CHK_BITS-1:0]     chk;
    } rec_t;

    typedef struct packed {
        logic [CW-1:0] ln;
        logic [CW-1:0] cn;
    } cnt_t;

    // memories
    rec_t slot_mem [SLOTS];
    cnt_t cnt_mem  [KKT_BUCKET_COUNT];

    state_t state_reg, state_next;
    after_t after_reg;

    logic [WORD_BITS-1:0]  local_reg [4];
    logic [2:0]            act_reg;
    logic [ID_BITS-1:0]    id_reg;
    logic [PAYLOAD_BITS-1:0] pay_reg;
    logic [CHK_BITS-1:0]   chk_reg;
    logic [1:0]            w_reg;
    logic [7:0]            bkt_reg;
    logic                  self_reg;
    logic [STAMP_BITS-1:0] stamp_reg;
    logic [KKT_BUCKET_COUNT-1:0] cnt_valid_reg;
    cnt_t                  cnt_rd_reg;
    logic                  cnt_ok_reg;
    logic [CW-1:0]         ln_reg, cn_reg, n_reg, iss_reg;
    logic                  list_reg;
    logic                  pend_reg;
    logic [IW-1:0]         pend_idx_reg;
    logic                  hit_reg;
    logic [IW-1:0]         hit_pos_reg, min_pos_reg, max_pos_reg;
    rec_t                  hit_rec_reg, max_rec_reg;
    logic [STAMP_BITS-1:0] min_stamp_reg;
    rec_t                  rd_data_reg;
    logic [AW-1:0]         wr_addr_reg;
    rec_t                  wr_rec_reg;
    logic [3:0]            status_reg;
    logic                  show_reg;
    logic                  out_valid_reg;
    logic [159:0]          out_data_reg;

    logic [WORD_BITS-1:0]  xw;
    logic [5:0]            msb;
    logic                  scan_done;
    logic                  issue;
    logic                  mem_we;
    logic [AW-1:0]         mem_wa;
    rec_t                  mem_wd;
    logic [AW-1:0]         mem_ra;
    logic                  cmp_match;
    logic                  out_free;
    logic [STAMP_BITS-1:0] tick;
    logic [CHK_BITS-1:0]   chk_inc;
    logic [IW-1:0]         ins_sel;
    rec_t                  new_rec;

    function automatic logic [WORD_BITS-1:0] s_word(input logic [1:0] w);
        logic [WORD_BITS-1:0] r;
        unique case (w)
            2'd0: r = id_reg[255:192];
            2'd1: r = id_reg[191:128];
            2'd2: r = id_reg[127:64];
            default: r = id_reg[63:0];
        endcase
        return r;
    endfunction

    // bucket search: highest differing bit, one word per cycle
    always_comb
    begin
        xw  = s_word(w_reg) ^ local_reg[w_reg];
        msb = '0;
        for (int b = 0; b < WORD_BITS; b++)
        begin
            if (xw[b])
            begin
                msb = 6'(b);
            end
        end
    end

    assign scan_done = (iss_reg == n_reg) && !pend_reg;
    assign issue     = (iss_reg < n_reg) &&
                       (state_reg == S_SCAN_LIVE || state_reg == S_SCAN_CACHE ||
                        state_reg == S_SHIFT);
    assign cmp_match = (rd_data_reg.id == id_reg);
    assign out_free  = !out_valid_reg || m_tready;
    assign tick      = stamp_reg + STAMP_BITS'(1);
    assign chk_inc   = (hit_rec_reg.chk != {CHK_BITS{1'b1}}) ?
                       hit_rec_reg.chk + CHK_BITS'(1) : hit_rec_reg.chk;
    assign ins_sel   = hit_reg ? hit_pos_reg :
                       (cn_reg < CW'(BUCKET_DEPTH)) ? cn_reg[IW-1:0] : min_pos_reg;

    always_comb
    begin
        new_rec.id    = id_reg;
        new_rec.pay   = pay_reg;
        new_rec.stamp = tick;
        new_rec.chk   = chk_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (s_tvalid) state_next = S_BKT;
            S_BKT:
                if (xw != '0) state_next = S_CNT_RD;
                else if (w_reg == 2'd3) state_next = S_FINISH;
            S_CNT_RD:
                state_next = S_CNT_GET;
            S_CNT_GET:
                state_next = (act_reg > ACT_DEAD) ? S_FINISH : S_SCAN_LIVE;
            S_SCAN_LIVE:
                if (scan_done)
                begin
                    unique case (act_reg)
                        ACT_INSERT:
                            state_next = hit_reg ? S_SHIFT :
                                         (ln_reg < CW'(BUCKET_DEPTH)) ? S_WRITE :
                                         S_SCAN_CACHE;
                        ACT_REMOVE, ACT_FIND:
                            state_next = hit_reg ?
                                         ((act_reg == ACT_FIND) ? S_FINISH : S_SHIFT) :
                                         S_SCAN_CACHE;
                        ACT_ALIVE, ACT_DEAD:
                            state_next = hit_reg ? S_SHIFT : S_FINISH;
                        default:
                            state_next = S_FINISH;
                    endcase
                end
            S_SCAN_CACHE:
                if (scan_done)
                begin
                    unique case (act_reg)
                        ACT_INSERT: state_next = S_WRITE;
                        ACT_REMOVE: state_next = hit_reg ? S_SHIFT : S_FINISH;
                        ACT_DEAD:   state_next = S_SHIFT;
                        default:    state_next = S_FINISH;
                    endcase
                end
            S_SHIFT:
                if (scan_done)
                begin
                    unique case (after_reg)
                        AFT_WRITE: state_next = S_WRITE;
                        AFT_SCAN:  state_next = S_SCAN_CACHE;
                        default:   state_next = S_FINISH;
                    endcase
                end
            S_WRITE:
                state_next = S_FINISH;
            S_FINISH:
                if (out_free) state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // outputs and memory port control
    always_comb
    begin
        s_tready = (state_reg == S_IDLE);
        mem_ra   = {bkt_reg, list_reg, iss_reg[IW-1:0]};
        mem_we   = 1'b0;
        mem_wa   = wr_addr_reg;
        mem_wd   = wr_rec_reg;
        if (state_reg == S_SHIFT && pend_reg)
        begin
            mem_we = 1'b1;
            mem_wa = {bkt_reg, list_reg, IW'(pend_idx_reg - IW'(1))};
            mem_wd = rd_data_reg;
        end
        else if (state_reg == S_WRITE)
        begin
            mem_we = 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // slot memory: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_wa] <= mem_wd;
        end
        if (issue)
        begin
            rd_data_reg <= slot_mem[mem_ra];
        end
    end

    // count memory
    always_ff @(posedge clk)
    begin
        if (state_reg == S_CNT_RD)
        begin
            cnt_rd_reg <= cnt_mem[bkt_reg];
        end
        if (state_reg == S_FINISH && out_free && !self_reg)
        begin
            cnt_mem[bkt_reg] <= '{ln: ln_reg, cn: cn_reg};
        end
    end

    task automatic start_scan(input logic lst, input logic [CW-1:0] n);
        list_reg <= lst;
        n_reg    <= n;
        iss_reg  <= '0;
        hit_reg  <= 1'b0;
    endtask

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            stamp_reg     <= '0;
            cnt_valid_reg <= '0;
            pend_reg      <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                local_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_LOCAL_W0: local_reg[0] <= cfg_data;
                    CFG_LOCAL_W1: local_reg[1] <= cfg_data;
                    CFG_LOCAL_W2: local_reg[2] <= cfg_data;
                    default:      local_reg[3] <= cfg_data;
                endcase
            end

            // drop a taken result unless a new one replaces it below
            if (out_valid_reg && m_tready && state_reg != S_FINISH)
            begin
                out_valid_reg <= 1'b0;
            end

            // scan and shift pipeline: issue a read, consume it next cycle
            pend_reg <= issue;
            if (issue)
            begin
                iss_reg      <= iss_reg + CW'(1);
                pend_idx_reg <= iss_reg[IW-1:0];
            end
            if (pend_reg && (state_reg == S_SCAN_LIVE || state_reg == S_SCAN_CACHE))
            begin
                if (cmp_match && !hit_reg)
                begin
                    hit_reg     <= 1'b1;
                    hit_pos_reg <= pend_idx_reg;
                    hit_rec_reg <= rd_data_reg;
                end
                if (pend_idx_reg == '0 || rd_data_reg.stamp < min_stamp_reg)
                begin
                    min_pos_reg   <= pend_idx_reg;
                    min_stamp_reg <= rd_data_reg.stamp;
                end
                if (pend_idx_reg == '0 || rd_data_reg.stamp > max_rec_reg.stamp)
                begin
                    max_pos_reg <= pend_idx_reg;
                    max_rec_reg <= rd_data_reg;
                end
            end

            unique case (state_reg)
                S_IDLE:
                    if (s_tvalid)
                    begin
                        act_reg  <= s_tdata[2:0];
                        id_reg   <= {s_tdata[66:3], s_tdata[130:67],
                                     s_tdata[194:131], s_tdata[258:195]};
                        pay_reg  <= s_tdata[259 +: PAYLOAD_BITS];
                        chk_reg  <= s_tdata[338:323];
                        w_reg    <= '0;
                        show_reg <= 1'b0;
                        self_reg <= 1'b0;
                        status_reg <= ST_NOT_FOUND;
                    end
                S_BKT:
                begin
                    w_reg <= w_reg + 2'd1;
                    if (xw != '0)
                    begin
                        bkt_reg <= {~w_reg, msb};
                    end
                    else if (w_reg == 2'd3)
                    begin
                        bkt_reg    <= '0;
                        self_reg   <= 1'b1;
                        status_reg <= ST_SELF;
                    end
                end
                S_CNT_RD:
                    cnt_ok_reg <= cnt_valid_reg[bkt_reg];
                S_CNT_GET:
                begin
                    ln_reg <= cnt_ok_reg ? cnt_rd_reg.ln : '0;
                    cn_reg <= cnt_ok_reg ? cnt_rd_reg.cn : '0;
                    start_scan(1'b0, cnt_ok_reg ? cnt_rd_reg.ln : '0);
                end
                S_SCAN_LIVE:
                    if (scan_done)
                    begin
                        // a hit shifts the live entries behind it, except for find
                        if (hit_reg)
                        begin
                            iss_reg <= CW'(hit_pos_reg) + CW'(1);
                            n_reg   <= ln_reg;
                        end
                        unique case (act_reg)
                            ACT_INSERT:
                                if (hit_reg)
                                begin
                                    wr_rec_reg  <= new_rec;
                                    stamp_reg   <= tick;
                                    wr_addr_reg <= {bkt_reg, 1'b0,
                                                    IW'(ln_reg - CW'(1))};
                                    after_reg   <= AFT_WRITE;
                                    status_reg  <= ST_UPDATED;
                                end
                                else if (ln_reg < CW'(BUCKET_DEPTH))
                                begin
                                    wr_rec_reg  <= new_rec;
                                    stamp_reg   <= tick;
                                    wr_addr_reg <= {bkt_reg, 1'b0, ln_reg[IW-1:0]};
                                    ln_reg      <= ln_reg + CW'(1);
                                    status_reg  <= ST_ADDED;
                                end
                                else
                                begin
                                    start_scan(1'b1, cn_reg);
                                end
                            ACT_REMOVE:
                                if (hit_reg)
                                begin
                                    ln_reg     <= ln_reg - CW'(1);
                                    after_reg  <= AFT_FINISH;
                                    status_reg <= ST_REMOVED;
                                end
                                else
                                begin
                                    start_scan(1'b1, cn_reg);
                                end
                            ACT_FIND:
                                if (hit_reg)
                                begin
                                    show_reg   <= 1'b1;
                                    status_reg <= ST_FOUND_LIVE;
                                end
                                else
                                begin
                                    start_scan(1'b1, cn_reg);
                                end
                            ACT_ALIVE:
                                if (hit_reg)
                                begin
                                    wr_rec_reg.id    <= hit_rec_reg.id;
                                    wr_rec_reg.pay   <= hit_rec_reg.pay;
                                    wr_rec_reg.stamp <= tick;
                                    wr_rec_reg.chk   <= chk_inc;
                                    stamp_reg        <= tick;
                                    wr_addr_reg      <= {bkt_reg, 1'b0,
                                                         IW'(ln_reg - CW'(1))};
                                    after_reg        <= AFT_WRITE;
                                    status_reg       <= ST_ALIVE;
                                end
                            ACT_DEAD:
                                if (hit_reg)
                                begin
                                    ln_reg     <= ln_reg - CW'(1);
                                    after_reg  <= (cn_reg != '0) ? AFT_SCAN : AFT_FINISH;
                                    status_reg <= ST_DEAD_NONE;
                                end
                            default:
                                status_reg <= ST_NOT_FOUND;
                        endcase
                    end
                S_SCAN_CACHE:
                    if (scan_done)
                    begin
                        unique case (act_reg)
                            ACT_INSERT:
                            begin
                                wr_rec_reg  <= new_rec;
                                stamp_reg   <= tick;
                                wr_addr_reg <= {bkt_reg, 1'b1, ins_sel};
                                if (!hit_reg && cn_reg < CW'(BUCKET_DEPTH))
                                begin
                                    cn_reg <= cn_reg + CW'(1);
                                end
                                status_reg <= ST_REPLACEMENT;
                            end
                            ACT_REMOVE:
                                if (hit_reg)
                                begin
                                    iss_reg    <= CW'(hit_pos_reg) + CW'(1);
                                    n_reg      <= cn_reg;
                                    cn_reg     <= cn_reg - CW'(1);
                                    after_reg  <= AFT_FINISH;
                                    status_reg <= ST_REMOVED;
                                end
                            ACT_FIND:
                                if (hit_reg)
                                begin
                                    show_reg   <= 1'b1;
                                    status_reg <= ST_FOUND_CACHE;
                                end
                            ACT_DEAD:
                            begin
                                wr_rec_reg.id    <= max_rec_reg.id;
                                wr_rec_reg.pay   <= max_rec_reg.pay;
                                wr_rec_reg.stamp <= tick;
                                wr_rec_reg.chk   <= max_rec_reg.chk;
                                stamp_reg        <= tick;
                                wr_addr_reg      <= {bkt_reg, 1'b0, ln_reg[IW-1:0]};
                                ln_reg           <= ln_reg + CW'(1);
                                iss_reg          <= CW'(max_pos_reg) + CW'(1);
                                n_reg            <= cn_reg;
                                cn_reg           <= cn_reg - CW'(1);
                                after_reg        <= AFT_WRITE;
                                status_reg       <= ST_DEAD_PROMO;
                            end
                            default:
                                status_reg <= ST_NOT_FOUND;
                        endcase
                    end
                S_SHIFT:
                    if (scan_done && after_reg == AFT_SCAN)
                    begin
                        start_scan(1'b1, cn_reg);
                    end
                S_WRITE:
                    ;
                S_FINISH:
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {4'b0,
                            show_reg ? hit_rec_reg.chk : {CHK_BITS{1'b0}},
                            show_reg ? hit_rec_reg.stamp : {STAMP_BITS{1'b0}},
                            show_reg ? 64'(hit_rec_reg.pay) : 64'b0,
                            bkt_reg, status_reg};
                        if (!self_reg)
                        begin
                            cnt_valid_reg[bkt_reg] <= 1'b1;
                        end
                    end
                default:
                    ;
            endcase
        end
    end

`ifndef ASSERT_OFF
    // the slot memory is only written while an item is in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_BKT) |-> !mem_we)
        else $error("slot write outside an operation");

    // the stamp clock advances by exactly one when it moves
    assert property (@(posedge clk) disable iff (!rst_n)
        (stamp_reg != $past(stamp_reg)) |-> (stamp_reg == $past(stamp_reg) + 64'd1))
        else $error("stamp clock jumped");

    // list lengths never exceed the bucket depth
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && !self_reg) |-> (ln_reg <= CW'(BUCKET_DEPTH) &&
                                                  cn_reg <= CW'(BUCKET_DEPTH)))
        else $error("bucket count overflow");
`endif

endmodule

[bench/kademlia_kbucket_table_top_tb.sv]
// ----------------------------------------------------------------------------
// kademlia_kbucket_table_top_tb
// Self-checking bench for the k-bucket routing table: drives insert, remove,
// find, mark-alive, mark-dead and unknown-action items over the input stream,
// predicts every result with a behavioral table and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module kademlia_kbucket_table_top_tb;
    import kkt_pkg::*;

    localparam int DEPTH = KKT_BUCKET_DEPTH;
    localparam int LIMIT = 3000000;

    typedef struct packed {
        logic [15:0] checks;
        logic [63:0] payload;
        logic [63:0] w3;
        logic [63:0] w2;
        logic [63:0] w1;
        logic [63:0] w0;
        logic [2:0]  action;
    } req_t;

    typedef struct packed {
        logic [15:0] checks;
        logic [63:0] stamp;
        logic [63:0] payload;
        logic [7:0]  bucket;
        logic [3:0]  status;
    } rsp_t;

    typedef struct {
        logic [255:0] id;
        logic [63:0]  payload;
        logic [63:0]  stamp;
        logic [15:0]  checks;
    } entry_t;

    // Behavioral routing table plus the queue of results still owed.
    class table_scoreboard;
        entry_t       live[256][$];
        entry_t       cache[256][$];
        logic [255:0] own_id;
        logic [63:0]  clock_now;
        rsp_t         owed[$];
        int           mismatches;
        int           checked;

        function void clear();
            for (int b = 0; b < 256; b++)
            begin
                live[b].delete();
                cache[b].delete();
            end
            own_id     = '0;
            clock_now  = '0;
            mismatches = 0;
            checked    = 0;
        endfunction

        function int find_pos(ref entry_t q[$], input logic [255:0] id);
            for (int i = 0; i < q.size(); i++)
                if (q[i].id == id)
                    return i;
            return -1;
        endfunction

        function void note_item(req_t r);
            rsp_t         e;
            logic [255:0] id;
            logic [255:0] x;
            entry_t       ent;
            int           b;
            int           p;
            int           sel;
            e  = '0;
            id = {r.w0, r.w1, r.w2, r.w3};
            x  = id ^ own_id;
            if (x == '0)
            begin
                e.status = ST_SELF;
                owed.push_back(e);
                return;
            end
            b = 0;
            for (int i = 0; i < 256; i++)
                if (x[i])
                    b = i;
            e.bucket = 8'(b);
            e.status = ST_NOT_FOUND;
            p = find_pos(live[b], id);
            case (r.action)
                ACT_INSERT:
                begin
                    clock_now++;
                    ent = '{id, r.payload, clock_now, r.checks};
                    if (p >= 0)
                    begin
                        live[b].delete(p);
                        live[b].push_back(ent);
                        e.status = ST_UPDATED;
                    end
                    else if (live[b].size() < DEPTH)
                    begin
                        live[b].push_back(ent);
                        e.status = ST_ADDED;
                    end
                    else
                    begin
                        p = find_pos(cache[b], id);
                        if (p >= 0)
                            cache[b][p] = ent;
                        else if (cache[b].size() < DEPTH)
                            cache[b].push_back(ent);
                        else
                        begin
                            // evict the oldest stamp, first one on a tie
                            sel = 0;
                            for (int i = 1; i < cache[b].size(); i++)
                                if (cache[b][i].stamp < cache[b][sel].stamp)
                                    sel = i;
                            cache[b][sel] = ent;
                        end
                        e.status = ST_REPLACEMENT;
                    end
                end
                ACT_REMOVE:
                begin
                    if (p >= 0)
                    begin
                        live[b].delete(p);
                        e.status = ST_REMOVED;
                    end
                    else
                    begin
                        p = find_pos(cache[b], id);
                        if (p >= 0)
                        begin
                            cache[b].delete(p);
                            e.status = ST_REMOVED;
                        end
                    end
                end
                ACT_FIND:
                begin
                    if (p >= 0)
                    begin
                        ent = live[b][p];
                        e.status = ST_FOUND_LIVE;
                    end
                    else
                    begin
                        p = find_pos(cache[b], id);
                        if (p >= 0)
                        begin
                            ent = cache[b][p];
                            e.status = ST_FOUND_CACHE;
                        end
                    end
                    if (p >= 0)
                    begin
                        e.payload = ent.payload;
                        e.stamp   = ent.stamp;
                        e.checks  = ent.checks;
                    end
                end
                ACT_ALIVE:
                begin
                    if (p >= 0)
                    begin
                        ent = live[b][p];
                        clock_now++;
                        ent.stamp = clock_now;
                        if (ent.checks != 16'hFFFF)
                            ent.checks++;
                        live[b].delete(p);
                        live[b].push_back(ent);
                        e.status = ST_ALIVE;
                    end
                end
                ACT_DEAD:
                begin
                    if (p >= 0)
                    begin
                        live[b].delete(p);
                        e.status = ST_DEAD_NONE;
                        if (cache[b].size() > 0)
                        begin
                            // promote the newest replacement, first on a tie
                            sel = 0;
                            for (int i = 1; i < cache[b].size(); i++)
                                if (cache[b][i].stamp > cache[b][sel].stamp)
                                    sel = i;
                            ent = cache[b][sel];
                            cache[b].delete(sel);
                            clock_now++;
                            ent.stamp = clock_now;
                            live[b].push_back(ent);
                            e.status = ST_DEAD_PROMO;
                        end
                    end
                end
                default:;
            endcase
            owed.push_back(e);
        endfunction

        function void check_result(rsp_t got);
            rsp_t e;
            if (owed.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", got);
                return;
            end
            e = owed.pop_front();
            checked++;
            if (got !== e)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: exp st=%0d bk=%0d pay=%h stp=%h chk=%h,",
                        checked, e.status, e.bucket, e.payload, e.stamp, e.checks,
                        " got st=%0d bk=%0d pay=%h stp=%h chk=%h",
                        got.status, got.bucket, got.payload, got.stamp, got.checks);
            end
        endfunction
    endclass

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [343:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [159:0] m_tdata;
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_index = '0;
    logic [63:0]  cfg_data = '0;

    table_scoreboard tbl;
    int           send_idle_pct;
    int           recv_stall_pct;
    int           cycles;
    int           items_sent;
    logic [255:0] pool[$];

    kademlia_kbucket_table_top dut (.*);

    always #2 clk = ~clk;

    // Count cycles and give up on a hang.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("kademlia_kbucket_table_top_tb failed");
            $finish;
        end
    end

    // Receiver: check every accepted result, stall at random.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                tbl.check_result(rsp_t'(m_tdata[155:0]));
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Present one item; hold it until accepted, with random idle before.
    task automatic send_item(req_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, r};
        do
            @(posedge clk);
        while (!s_tready);
        tbl.note_item(r);
        items_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (tbl.owed.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    // Write the local id while the block is idle.
    task automatic set_local(logic [255:0] id);
        for (int w = 0; w < 4; w++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= w[1:0];
            cfg_data  <= id[255 - 64*w -: 64];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        tbl.own_id = id;
        pool.delete();
    endtask

    function automatic req_t make_req(logic [2:0] act, logic [255:0] id);
        req_t r;
        r.action  = act;
        {r.w0, r.w1, r.w2, r.w3} = id;
        r.payload = {$urandom, $urandom};
        r.checks  = 16'($urandom);
        return r;
    endfunction

    function automatic logic [255:0] rand_wide();
        return {$urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom};
    endfunction

    // Node id landing in bucket b, i.e. highest differing bit at b.
    function automatic logic [255:0] id_in_bucket(int b);
        logic [255:0] m;
        m = (b == 255) ? '1 : ((256'b1 << (b + 1)) - 1);
        return tbl.own_id ^ ((rand_wide() & m) | (256'b1 << b));
    endfunction

    // Mostly ids from a small pool of crowded buckets, so lists fill up.
    function automatic logic [255:0] pick_id();
        int  k;
        int  bk[4] = '{0, 7, 128, 255};
        k = $urandom_range(99);
        if (k < 3)
            return tbl.own_id;
        if (k < 10)
            return rand_wide();
        if (pool.size() > 0 && k < 70)
            return pool[$urandom_range(pool.size() - 1)];
        pool.push_back(id_in_bucket(bk[$urandom_range(3)]));
        if (pool.size() > 120)
            pool.delete(0);
        return pool[pool.size() - 1];
    endfunction

    task automatic random_phase(int n, int idle, int stall);
        req_t r;
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < n; i++)
        begin
            r = make_req(3'($urandom_range(99) < 3 ? $urandom_range(7, 5)
                                                   : $urandom_range(4)),
                         pick_id());
            if ($urandom_range(9) == 0)
                r.checks = ($urandom_range(1)) ? 16'hFFFF : 16'h0;
            send_item(r);
        end
    endtask

    initial
    begin
        logic [255:0] ids[$];
        logic [255:0] x;
        req_t         r;
        tbl = new();
        tbl.clear();
        cycles = 0;
        items_sent = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: local id zero; self, extreme buckets, every action,
        // fill a bucket past its live depth, saturate checks, promote.
        r = make_req(ACT_FIND, '0);
        send_item(r);
        send_item(make_req(ACT_INSERT, 256'h1));
        r = make_req(ACT_INSERT, '1);
        r.payload = '1;
        r.checks  = 16'hFFFF;
        send_item(r);
        send_item(make_req(ACT_ALIVE, '1));
        send_item(make_req(ACT_FIND, '1));
        send_item(make_req(ACT_FIND, 256'h2));
        send_item(make_req(3'd7, 256'h1));
        for (int i = 0; i < DEPTH + 2; i++)
            ids.push_back(id_in_bucket(9));
        foreach (ids[i])
            send_item(make_req(ACT_INSERT, ids[i]));
        send_item(make_req(ACT_FIND, ids[DEPTH]));
        send_item(make_req(ACT_DEAD, ids[0]));
        send_item(make_req(ACT_DEAD, 256'h1));
        send_item(make_req(ACT_REMOVE, ids[DEPTH + 1]));
        send_item(make_req(ACT_REMOVE, ids[2]));
        send_item(make_req(ACT_ALIVE, 256'h3));
        // hold off until the table has answered everything
        drain();

        // Phases with the four idling mixes and several local ids.
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: x = '1;
                1: x = '0;
                2: x = 256'h1 << 255;
                default: x = rand_wide();
            endcase
            set_local(x);
            random_phase(290, (ph % 4 == 1 || ph % 4 == 3) ? (ph % 4 == 3 ? 28 : 49) : 0,
                              (ph % 4 == 2 || ph % 4 == 3) ? (ph % 4 == 3 ? 28 : 49) : 0);
            drain();
        end

        $display("covered %0d items over 6 local ids and four idling mixes, %0d results",
                 items_sent, tbl.checked);
        if (tbl.mismatches == 0 && tbl.owed.size() == 0)
            $display("kademlia_kbucket_table_top_tb passed");
        else
            $display("kademlia_kbucket_table_top_tb failed");
        $finish;
    end
endmodule

[files.f]
src/kkt_pkg.sv
src/kademlia_kbucket_table_top.sv
bench/kademlia_kbucket_table_top_tb.sv
